// File: hdl/hfdb_pkg.sv
// Shared constants, state type and coefficient tables of the Hann/DFT dB spectrum analyzer.
package hfdb_pkg;

  localparam int FftSize   = 128;
  localparam int BinCount  = 64;
  localparam int AddrW     = $clog2(FftSize);
  localparam int BinW      = $clog2(BinCount);
  localparam int SampleW   = 16;
  localparam int CoefW     = 17;
  localparam int LevelW    = 16;
  localparam int HopW      = 8;
  localparam int HopMax    = 128;
  localparam int AmpShift  = AddrW - 2;

  // datapath widths
  localparam int XW        = 32;  // windowed sample, Q30
  localparam int ProdW     = 48;  // sample times twiddle, Q45
  localparam int AccW      = 54;  // bin sum over the whole frame
  localparam int RndShift  = 25;  // Q45 -> Q20
  localparam int RqW       = AccW - RndShift;
  localparam int SqW       = 2 * RqW;
  localparam int RootW     = (SqW + 2) / 2;
  localparam int RadW      = 2 * RootW;
  localparam int RemW      = RootW + 3;
  localparam int AmpW      = RootW - AmpShift;
  localparam int ExpW      = $clog2(AmpW);
  localparam int MW        = 31;  // log2 mantissa, Q30
  localparam int FracW     = 20;
  localparam int LW        = FracW + 6;
  localparam int SclW      = 57;
  localparam int CntW      = 5;
  localparam int SqrtSteps = RootW;
  localparam int LogSteps  = FracW;

  localparam logic [AmpW-1:0]        AmpFloor  = AmpW'(1048);
  localparam logic signed [30:0]     DbSlope   = 31'sd323228497;
  localparam logic signed [SclW-1:0] LevelBias = SclW'(49152) <<< 36;
  localparam logic signed [SclW-1:0] LevelRnd  = SclW'(1) <<< 35;

  localparam logic [63:0] Q30One = 64'd1 << 30;
  localparam logic [63:0] PiQ30  = 64'd3373259426;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_ROUND,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_AMP,
    ST_NORM,
    ST_LOG,
    ST_SCALE,
    ST_FINAL,
    ST_OUT
  } state_e;

  typedef logic [FftSize-1:0][CoefW-1:0] coef_rom_t;

  // sine of a phase in 2^-32 turns, Q30
  function automatic logic signed [31:0] sine_q30(input logic [31:0] phase);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    quad = phase[31:30];
    r    = {34'd0, phase[29:0]};
    if (quad[0]) begin
      r = Q30One - r;
    end
    x  = (r * PiQ30) >> 31;
    x2 = (x * x) >> 30;
    // Horner steps of the Taylor series, highest term first
    t  = Q30One;
    t  = Q30One - (((x2 * t) >> 30) / 64'd156);
    t  = Q30One - (((x2 * t) >> 30) / 64'd110);
    t  = Q30One - (((x2 * t) >> 30) / 64'd72);
    t  = Q30One - (((x2 * t) >> 30) / 64'd42);
    t  = Q30One - (((x2 * t) >> 30) / 64'd20);
    t  = Q30One - (((x2 * t) >> 30) / 64'd6);
    s = (x * t) >> 30;
    if (s > Q30One) begin
      s = Q30One;
    end
    return quad[1] ? -s[31:0] : s[31:0];
  endfunction

  function automatic logic [CoefW-1:0] round_q15(input logic signed [31:0] v);
    logic [32:0] m;
    m = v[31] ? -{v[31], v} : {1'b0, v};
    m = (m + 33'd16384) >> 15;
    return v[31] ? -m[CoefW-1:0] : m[CoefW-1:0];
  endfunction

  function automatic coef_rom_t hann_table();
    coef_rom_t          rom;
    logic [63:0]        ph;
    logic [63:0]        one_minus;
    logic signed [31:0] c;
    for (int n = 0; n < FftSize; n++) begin
      ph        = ((64'(n) << 32) + 64'((FftSize - 1) / 2)) / 64'(FftSize - 1);
      c         = sine_q30(ph[31:0] + 32'h4000_0000);
      one_minus = Q30One - 64'(c);
      rom[n]    = CoefW'((one_minus + 64'd32768) >> 16);
    end
    return rom;
  endfunction

  function automatic coef_rom_t twiddle_table(input logic [31:0] offset);
    coef_rom_t   rom;
    logic [63:0] tph;
    for (int n = 0; n < FftSize; n++) begin
      tph    = (64'(n) << 32) / 64'(FftSize);
      rom[n] = round_q15(sine_q30(tph[31:0] + offset));
    end
    return rom;
  endfunction

  localparam coef_rom_t HannRom  = hann_table();
  localparam coef_rom_t TwCosRom = twiddle_table(32'h4000_0000);
  localparam coef_rom_t TwSinRom = twiddle_table(32'h0000_0000);

endpackage

// File: hdl/hann_fft_magnitude_db_analyzer.sv
// Hann windowed sliding DFT analyzer: sample ring, per-bin MAC, sqrt, log2 and dB level mapping.
// Samples: one per cycle while idle, no result. Request with ready mark: 64 results, one bin
// after another; each bin runs a MAC pass over the ring memory, a bit-serial square root,
// normalization and 20 log2 steps.
// Inputs are held off (s_axis_tready low) until the last bin has been taken.
// Reset: async active low; ring reads as zero until written (fill flag), hop 32, mark cleared.
module hann_fft_magnitude_db_analyzer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // hop length register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hfdb_pkg::HopW-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] sample
  input  logic [0:0]                    s_axis_tuser,   // [0] kind: 0 sample, 1 request
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // [5:0] bin_index, [21:6] level
  output logic                          m_axis_tlast    // last_bin
);
  import hfdb_pkg::*;

  state_e state_q, state_d;

  // control
  logic [HopW-1:0]  hop_len_q;
  logic [AddrW:0]   eff_hop;
  logic [AddrW:0]   hop_inc;
  logic [AddrW-1:0] wp_q;
  logic             wrapped_q;
  logic [AddrW-1:0] hop_cnt_q;
  logic             ready_q;
  logic [AddrW:0]   n_q;
  logic [AddrW-1:0] tw_q;
  logic [BinW-1:0]  k_q;
  logic [CntW-1:0]  cnt_q;
  logic             v1_q, v2_q, v3_q;

  logic in_acc, ring_we, start, issue, out_take, last_bin, bin_start;

  // ring memory
  logic [SampleW-1:0] ring_mem [FftSize];
  logic [SampleW-1:0] rd_data_q;
  logic [AddrW-1:0]   rd_addr;
  logic               rd_ok, rd_ok_q;

  // MAC pipeline
  logic [AddrW-1:0]          hidx_q, tidx1_q, tidx2_q;
  logic signed [SampleW-1:0] samp;
  logic signed [33:0]        xw;
  logic signed [XW-1:0]      x_q;
  logic signed [48:0]        pcw, psw;
  logic signed [ProdW-1:0]   pc_q, ps_q;
  logic signed [AccW-1:0]    acc_re_q, acc_im_q;

  // post processing
  logic [AccW-1:0]   re_abs, im_abs, re_rnd, im_rnd;
  logic [RqW-1:0]    rq_q, iq_q;
  logic [SqW-1:0]    re_sq_q, im_sq_q;
  logic [RadW-1:0]   rad_q;
  logic [RemW-1:0]   rem_q, rem_n, trial;
  logic [RootW-1:0]  root_q;
  logic [AmpW-1:0]   amp, nrm_q;
  logic [ExpW-1:0]   e_q;
  logic [MW-1:0]     m_q;
  logic [2*MW-1:0]   msq;
  logic [FracW-1:0]  frac_q;
  logic signed [5:0] ediff;
  logic signed [LW-1:0]   l_val;
  logic signed [SclW-1:0] prod_q, v_val, v_rnd;
  logic [LevelW-1:0] level_q;

  // handshake decode
  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign ring_we   = in_acc & ~s_axis_tuser[0];
  assign start     = in_acc & s_axis_tuser[0] & ready_q;
  assign last_bin  = (k_q == BinW'(BinCount - 1));
  assign out_take  = (state_q == ST_OUT) & m_axis_tready;
  assign bin_start = start | (out_take & ~last_bin);
  assign cfg_ready_o = 1'b1;

  // hop clamp: zero acts as one, above the ring size acts as the ring size
  always_comb begin
    if (hop_len_q == '0) begin
      eff_hop = (AddrW + 1)'(1);
    end else if (hop_len_q > HopW'(HopMax)) begin
      eff_hop = (AddrW + 1)'(HopMax);
    end else begin
      eff_hop = (AddrW + 1)'(hop_len_q);
    end
  end
  assign hop_inc = {1'b0, hop_cnt_q} + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_ACC;
      ST_ACC:    if (n_q == (AddrW + 1)'(FftSize) && !(v1_q | v2_q | v3_q)) state_d = ST_ROUND;
      ST_ROUND:  state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_SUM;
      ST_SUM:    state_d = ST_SQRT;
      ST_SQRT:   if (cnt_q == CntW'(SqrtSteps - 1)) state_d = ST_AMP;
      ST_AMP:    state_d = (amp <= AmpFloor) ? ST_OUT : ST_NORM;
      ST_NORM:   if (nrm_q[AmpW-1]) state_d = ST_LOG;
      ST_LOG:    if (cnt_q == CntW'(LogSteps - 1)) state_d = ST_SCALE;
      ST_SCALE:  state_d = ST_FINAL;
      ST_FINAL:  state_d = ST_OUT;
      ST_OUT: begin
        if (m_axis_tready) begin
          state_d = last_bin ? ST_IDLE : ST_ACC;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT);
    issue         = (state_q == ST_ACC) && (n_q < (AddrW + 1)'(FftSize));
    m_axis_tdata  = {2'b00, level_q, k_q};
    m_axis_tlast  = last_bin;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hop_len_q <= HopW'(32);
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      hop_cnt_q <= '0;
      ready_q   <= 1'b0;
      n_q       <= '0;
      tw_q      <= '0;
      k_q       <= '0;
      cnt_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        hop_len_q <= cfg_data_i;
      end
      if (ring_we) begin
        wp_q <= wp_q + 1'b1;
        if (wp_q == AddrW'(FftSize - 1)) begin
          wrapped_q <= 1'b1;
        end
        if (hop_inc >= eff_hop) begin
          hop_cnt_q <= '0;
          ready_q   <= 1'b1;
        end else begin
          hop_cnt_q <= hop_inc[AddrW-1:0];
        end
      end
      if (start) begin
        ready_q <= 1'b0;
        k_q     <= '0;
      end else if (out_take && !last_bin) begin
        k_q <= k_q + 1'b1;
      end
      if (bin_start) begin
        n_q  <= '0;
        tw_q <= '0;
      end else if (issue) begin
        n_q  <= n_q + 1'b1;
        tw_q <= tw_q + AddrW'(k_q);   // k*n mod N
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (state_q == ST_SUM || (state_q == ST_NORM && nrm_q[AmpW-1])) begin
        cnt_q <= '0;
      end else if (state_q == ST_SQRT || state_q == ST_LOG) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // ring: oldest sample sits at the write pointer
  assign rd_addr = wp_q + n_q[AddrW-1:0];
  assign rd_ok   = wrapped_q | (rd_addr < wp_q);

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_q] <= s_axis_tdata[SampleW-1:0];
    end
    rd_data_q <= ring_mem[rd_addr];
  end

  // MAC pipeline: read, window, twiddle, accumulate
  assign samp = rd_ok_q ? $signed(rd_data_q) : '0;
  assign xw   = samp * $signed({1'b0, HannRom[hidx_q]});
  assign pcw  = x_q * $signed(TwCosRom[tidx2_q]);
  assign psw  = x_q * $signed(TwSinRom[tidx2_q]);

  // rounding of the sums to Q20, ties away from zero
  assign re_abs = acc_re_q[AccW-1] ? AccW'(-acc_re_q) : AccW'(acc_re_q);
  assign im_abs = acc_im_q[AccW-1] ? AccW'(-acc_im_q) : AccW'(acc_im_q);
  assign re_rnd = re_abs + (AccW'(1) << (RndShift - 1));
  assign im_rnd = im_abs + (AccW'(1) << (RndShift - 1));

  // square root step, two radicand bits a cycle
  assign rem_n = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  // amplitude = 4*mag/N
  assign amp = root_q[RootW-1:AmpShift];

  // log2 fraction by repeated squaring
  assign msq = m_q * m_q;

  assign ediff = $signed({1'b0, e_q}) - 6'sd20;
  assign l_val = $signed({ediff, frac_q});
  assign v_val = prod_q + LevelBias;
  assign v_rnd = v_val + LevelRnd;

  always_ff @(posedge clk_i) begin
    rd_ok_q <= rd_ok;
    hidx_q  <= n_q[AddrW-1:0];
    tidx1_q <= tw_q;
    x_q     <= xw[XW-1:0];
    tidx2_q <= tidx1_q;
    pc_q    <= pcw[ProdW-1:0];
    ps_q    <= psw[ProdW-1:0];
    if (bin_start) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v3_q) begin
      acc_re_q <= acc_re_q + AccW'(pc_q);
      acc_im_q <= acc_im_q - AccW'(ps_q);
    end
    case (state_q)
      ST_ROUND: begin
        rq_q <= re_rnd[AccW-1:RndShift];
        iq_q <= im_rnd[AccW-1:RndShift];
      end
      ST_SQUARE: begin
        re_sq_q <= rq_q * rq_q;
        im_sq_q <= iq_q * iq_q;
      end
      ST_SUM: begin
        rad_q  <= RadW'(re_sq_q) + RadW'(im_sq_q);
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        rad_q <= rad_q << 2;
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      ST_AMP: begin
        nrm_q   <= amp;
        e_q     <= ExpW'(AmpW - 1);
        level_q <= '0;             // below the -60 dB floor
      end
      ST_NORM: begin
        if (!nrm_q[AmpW-1]) begin
          nrm_q <= nrm_q << 1;
          e_q   <= e_q - 1'b1;
        end else begin
          m_q    <= {nrm_q, (MW - AmpW)'(0)};
          frac_q <= '0;
        end
      end
      ST_LOG: begin
        if (msq[2*MW-1]) begin
          m_q    <= msq[2*MW-1:MW];
          frac_q <= {frac_q[FracW-2:0], 1'b1};
        end else begin
          m_q    <= msq[2*MW-2:MW-1];
          frac_q <= {frac_q[FracW-2:0], 1'b0};
        end
      end
      ST_SCALE: begin
        prod_q <= l_val * DbSlope;
      end
      ST_FINAL: begin
        if (v_val[SclW-1]) begin
          level_q <= '0;
        end else if (|v_rnd[SclW-2:36+LevelW]) begin
          level_q <= '1;
        end else begin
          level_q <= v_rnd[36 +: LevelW];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: test/tb_hann_fft_magnitude_db_analyzer.sv
// Self-checking testbench of the Hann windowed dB spectrum analyzer.
module tb_hann_fft_magnitude_db_analyzer;
  timeunit 1ns;
  timeprecision 1ps;

  import hfdb_pkg::*;

  localparam logic KindSample  = 1'b0;
  localparam logic KindRequest = 1'b1;
  localparam int   StallLimit  = 20000;  // cycles with no request moving on any channel
  localparam int   DrainCycles = 300;    // > worst per-bin time after the last result
  localparam int   HoldCycles  = 3000;   // long receiver hold-off

  typedef struct packed {
    logic [BinW-1:0]   bin;
    logic [LevelW-1:0] level;
    logic              last;
  } bin_result_t;

  // Spectrum predictor plus queue of bins still owed by the block.
  class spectrum_board;
    bin_result_t               owed_bins[$];
    int                        errors;
    logic [HopW-1:0]           hop_reg;
    logic signed [SampleW-1:0] ring[FftSize];
    int                        wr_pos;
    int                        hop_cnt;
    bit                        ready_mark;
    longint                    hann_w[FftSize];
    longint                    tw_c[FftSize];
    longint                    tw_s[FftSize];

    function new();
      logic [63:0] ph;
      logic [63:0] one_minus;
      logic [31:0] tph;
      longint      c;
      errors     = 0;
      hop_reg    = 8'd32;
      wr_pos     = 0;
      hop_cnt    = 0;
      ready_mark = 0;
      for (int n = 0; n < FftSize; n++) begin
        ring[n]   = '0;
        ph        = ((64'(n) << 32) + 64'((FftSize - 1) / 2)) / 64'(FftSize - 1);
        c         = longint'(sin_q30(ph[31:0] + 32'h4000_0000));
        one_minus = 64'(longint'(1) << 30) - 64'(c);
        hann_w[n] = longint'((one_minus + 64'd32768) >> 16);
        tph       = 32'((64'(n) << 32) / 64'(FftSize));
        tw_c[n]   = round_shift(longint'(sin_q30(tph + 32'h4000_0000)), 15);
        tw_s[n]   = round_shift(longint'(sin_q30(tph)), 15);
      end
    endfunction

    // round to nearest, ties away from zero
    function longint round_shift(longint v, int s);
      logic [63:0] m;
      m = (v < 0) ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (s - 1))) >> s;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    // sine of a 2^-32 turn phase in Q30, Taylor series per quadrant
    function logic signed [31:0] sin_q30(logic [31:0] phase);
      logic [63:0] divs[6];
      logic [63:0] one;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      one  = 64'd1 << 30;
      r    = {34'd0, phase[29:0]};
      if (phase[30]) begin
        r = one - r;
      end
      x  = (r * 64'd3373259426) >> 31;
      x2 = (x * x) >> 30;
      t  = one;
      for (int i = 0; i < 6; i++) begin
        t = one - (((x2 * t) >> 30) / divs[i]);
      end
      s = (x * t) >> 30;
      if (s > one) begin
        s = one;
      end
      return phase[31] ? -s[31:0] : s[31:0];
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // log2 of a Q20 value, Q20
    function longint log2_q20(logic [63:0] a);
      int          e;
      logic [63:0] m;
      longint      frac;
      e    = 63;
      frac = 0;
      while (e > 0 && a[e] == 1'b0) e--;
      m = (e <= 30) ? (a << (30 - e)) : (a >> (e - 30));
      for (int i = 19; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          frac |= longint'(1) << i;
        end
      end
      return longint'(e - 20) * (longint'(1) << 20) + frac;
    endfunction

    function logic [LevelW-1:0] bin_level(int k);
      longint      re;
      longint      im;
      longint      x;
      longint      lg;
      longint      v;
      logic [63:0] rq;
      logic [63:0] iq;
      logic [63:0] amp;
      int          idx;
      re  = 0;
      im  = 0;
      idx = wr_pos;
      for (int n = 0; n < FftSize; n++) begin
        x   = longint'(ring[idx]) * hann_w[n];
        re += x * tw_c[(k * n) % FftSize];
        im -= x * tw_s[(k * n) % FftSize];
        idx = (idx + 1) % FftSize;
      end
      re  = round_shift(re, 25);
      im  = round_shift(im, 25);
      rq  = (re < 0) ? 64'(-re) : 64'(re);
      iq  = (im < 0) ? 64'(-im) : 64'(im);
      amp = (floor_sqrt(rq * rq + iq * iq) * 4) / FftSize;
      if (amp <= 64'd1048) begin
        return '0;
      end
      lg = log2_q20(amp);
      v  = (longint'(49152) << 36) + lg * longint'(323228497);
      if (v < 0) begin
        return '0;
      end
      v = (v + (longint'(1) << 35)) >>> 36;
      return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function void set_hop(logic [HopW-1:0] hop);
      hop_reg = hop;
    endfunction

    // accepted input request: update state, queue owed bins
    function void note_input(logic kind, logic [15:0] smp);
      int          hop;
      bin_result_t b;
      if (kind == KindSample) begin
        hop = (hop_reg == 0) ? 1 : ((hop_reg > HopMax) ? HopMax : int'(hop_reg));
        ring[wr_pos] = smp;
        wr_pos       = (wr_pos + 1) % FftSize;
        hop_cnt++;
        if (hop_cnt >= hop) begin
          hop_cnt    = 0;
          ready_mark = 1;
        end
      end else if (ready_mark) begin
        ready_mark = 0;
        for (int k = 0; k < BinCount; k++) begin
          b.bin     = BinW'(k);
          b.level   = bin_level(k);
          b.last    = (k == BinCount - 1);
          owed_bins = {owed_bins, b};
        end
      end
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [23:0] data, logic last);
      bin_result_t e;
      if (owed_bins.size() == 0) begin
        report($sformatf("unexpected result %h last %0b", data, last));
        return;
      end
      e = owed_bins.pop_front();
      if (data[5:0] !== e.bin)
        report($sformatf("bin_index %0d, want %0d", data[5:0], e.bin));
      if (data[21:6] !== e.level)
        report($sformatf("bin %0d level %0d, want %0d", e.bin, data[21:6], e.level));
      if (last !== e.last)
        report($sformatf("bin %0d last_bin %0b, want %0b", e.bin, last, e.last));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [HopW-1:0]       cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata;   // [15:0] sample
  logic [0:0]            s_axis_tuser;   // [0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [23:0]           m_axis_tdata;   // [5:0] bin_index, [21:6] level
  logic                  m_axis_tlast;

  spectrum_board board;
  int            send_idle_pct;   // sender idle chance per cycle
  int            recv_stall_pct;  // receiver stall chance per cycle
  int            hold_left;       // receiver hold-off cycles still to go
  int            quiet_cycles;

  hann_fft_magnitude_db_analyzer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver: checks each accepted bin, then picks next tready (one NBA per edge)
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        board.check_result(m_axis_tdata, m_axis_tlast);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: ends the run if nothing moves for too long
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no request moved for %0d cycles", StallLimit);
        $display("tb_hann_fft_magnitude_db_analyzer: done, errors");
        $finish;
      end
    end
  end

  // one input request; tvalid stays high if the next one follows at once
  task automatic send_item(logic kind, logic [15:0] smp);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(kind, smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // wait until every owed bin has come, then let the block settle for DrainCycles
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.owed_bins.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_hop(logic [HopW-1:0] hop);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hop;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_hop(hop);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n_items, int req_pct);
    logic [15:0] smp;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(3))
        0:       smp = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        default: smp = 16'($urandom_range(16'hFFFF));
      endcase
      send_item(($urandom_range(99) < req_pct) ? KindRequest : KindSample, smp);
    end
  endtask

  initial begin
    logic [HopW-1:0] hops[5];
    int              idle_tab[5];
    int              stall_tab[5];
    int              cnt_tab[5];
    int              req_tab[5];
    board          = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = KindSample;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: request with no mark, then 16 samples at reset hop of 32
    send_item(KindRequest, 16'h0000);
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_item(KindSample, 16'h7FFF);
        1: send_item(KindSample, 16'h8000);
        2: send_item(KindSample, 16'hFFFF);
        default: send_item(KindSample, 16'h0001);
      endcase
    end
    // long hold-off on the result side while the next sample is held off at the input
    send_item(KindRequest, 16'hFFFF);  // no mark yet: 16 of 32 samples
    for (int i = 0; i < 16; i++) send_item(KindSample, (i % 2) ? 16'h5A5A : 16'hA5A5);
    hold_left = HoldCycles;
    send_item(KindRequest, 16'h0000);
    send_item(KindSample, 16'h0000);
    send_item(KindRequest, 16'h0000);  // mark already used
    // pause until every owed bin is in
    drain();

    // extremes of the hop register
    write_hop(8'd0);
    send_item(KindSample, 16'h7FFF);
    send_item(KindRequest, 16'h0000);

    // large hops only count here; the count carried into hop 23 is above it
    hops      = '{8'd1, 8'd9, 8'd128, 8'd255, 8'd23};
    cnt_tab   = '{16, 26, 20, 20, 30};
    req_tab   = '{10, 10, 0, 0, 10};
    idle_tab  = '{20, 85, 0, 0, 0};
    stall_tab = '{20, 0, 0, 0, 85};
    for (int p = 0; p < 5; p++) begin
      write_hop(hops[p]);
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      random_phase(cnt_tab[p], req_tab[p]);
      send_item(KindRequest, 16'h0000);
    end

    drain();
    if (board.errors == 0) begin
      $display("tb_hann_fft_magnitude_db_analyzer: done, clean");
    end else begin
      $display("tb_hann_fft_magnitude_db_analyzer: done, errors");
    end
    $finish;
  end

endmodule
